/* sv/mavg_pkg.sv */
// Shared constants and types for the moving-average ring buffer.
// No dependencies; every other source file imports this package.
package mavg_pkg;

  localparam int MAX_DEPTH   = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int PTR_W     = $clog2(MAX_DEPTH);
  localparam int LEN_W     = $clog2(MAX_DEPTH + 1);
  localparam int SUM_W     = SAMPLE_BITS + LEN_W;
  localparam int CFG_W     = 7;
  localparam int FILL_W    = 7;
  localparam int OUT_SUM_W = 22;
  localparam int STEP_W    = $clog2(SUM_W + 1);

  typedef enum logic {
    CMD_PUT = 1'b0,
    CMD_GET = 1'b1
  } cmd_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

endpackage

/* sv/moving_average_ring_buffer.sv */
// Moving-average ring buffer, top level.
// Depends on mavg_pkg, mavg_ram and mavg_div.
//
// Input channel (in_valid / in_stall): command and sample. A put stores the
//   sample, dropping the oldest one first when the window is full; a get pops
//   the oldest sample, or reports status empty when none is held.
// Output channel (out_valid / out_stall): one result per input transfer:
//   status, popped value, fill count, window sum and average (sum / count
//   truncated toward zero, 0 when empty).
// Config channel (cfg_valid / cfg_ready, data on window_length): window
//   length; 0 acts as 1, above the store depth acts as the depth. A write
//   restarts the ring (pointers, count and sum cleared).
// Timing: one item at a time: accept, a read-modify-write step on the store,
//   23 divide steps (SUM_W), the quotient taken when the divider is done, then
//   the output register loaded. The next input is taken only after the result
//   is loaded. A step that leaves the window empty skips the divide.
// Reset (rst, synchronous): ring empty, window length at full depth, output
//   channel empty. The store itself is not cleared; only held entries are read.
// Stall: a finished result waits in the output register; the next input is
//   already taken and processed, but its result waits until the slot frees.
module moving_average_ring_buffer
  import mavg_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_W-1:0]              window_length,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic signed [SAMPLE_BITS-1:0] sample,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic signed [SAMPLE_BITS-1:0] popped_value,
  output logic [FILL_W-1:0]             fill_count,
  output logic signed [OUT_SUM_W-1:0]   window_sum,
  output logic signed [SAMPLE_BITS-1:0] average
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DIV,
    S_OUT
  } state_t;

  state_t                        state;
  logic [LEN_W-1:0]              len_act;
  logic [PTR_W-1:0]              wr_ptr;
  logic [PTR_W-1:0]              rd_ptr;
  logic [LEN_W-1:0]              count;
  logic signed [SUM_W-1:0]       sum;
  cmd_t                          cmd_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          status_r;
  logic signed [SAMPLE_BITS-1:0] popped_r;
  logic signed [SAMPLE_BITS-1:0] avg_r;

  // read-modify-write terms, valid in S_UPD
  logic                          is_put;
  logic                          full;
  logic                          held;
  logic                          drop;
  logic signed [SAMPLE_BITS-1:0] rdata;
  logic signed [SUM_W-1:0]       sum_next;
  logic [LEN_W-1:0]              count_next;
  logic [PTR_W-1:0]              wr_ptr_next;
  logic [PTR_W-1:0]              rd_ptr_next;
  logic [LEN_W-1:0]              len_cfg;

  logic                          in_xfer;
  logic                          cfg_xfer;
  logic                          out_free;
  logic                          div_start;
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] div_quo;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [LEN_W-1:0] len);
    logic [LEN_W:0] n;
    n = {1'b0, LEN_W'(p)} + (LEN_W+1)'(1);
    return (n >= {1'b0, len}) ? '0 : n[PTR_W-1:0];
  endfunction

  assign cfg_ready = (state == S_IDLE);
  assign cfg_xfer  = cfg_valid && cfg_ready;
  // config has priority; an input is only taken when no config is offered
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // clamp the written length into 1..MAX_DEPTH
  always_comb begin
    if (window_length == '0) begin
      len_cfg = LEN_W'(1);
    end else if (int'(window_length) > MAX_DEPTH) begin
      len_cfg = LEN_W'(MAX_DEPTH);
    end else begin
      len_cfg = LEN_W'(window_length);
    end
  end

  always_comb begin
    is_put = (cmd_r == CMD_PUT);
    full   = (count >= len_act);
    held   = (count != '0);
    drop   = is_put ? full : held;

    sum_next = sum;
    if (drop) begin
      sum_next = sum_next - SUM_W'(rdata);
    end
    if (is_put) begin
      sum_next = sum_next + SUM_W'(sample_r);
    end

    count_next = count;
    if (is_put && !full) begin
      count_next = count + LEN_W'(1);
    end else if (!is_put && held) begin
      count_next = count - LEN_W'(1);
    end

    rd_ptr_next = drop   ? advance(rd_ptr, len_act) : rd_ptr;
    wr_ptr_next = is_put ? advance(wr_ptr, len_act) : wr_ptr;
  end

  assign div_start = (state == S_UPD) && (count_next != '0);

  mavg_ram u_ram (
    .clk   (clk),
    .we    (state == S_UPD && is_put),
    .waddr (wr_ptr),
    .wdata (sample_r),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  mavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (count_next),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len_act   <= LEN_W'(MAX_DEPTH);
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a new result, or drop the one just transferred
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_xfer) begin
            len_act <= len_cfg;
            wr_ptr  <= '0;
            rd_ptr  <= '0;
            count   <= '0;
            sum     <= '0;
          end else if (in_xfer) begin
            // store read of the oldest entry is issued this cycle
            state <= S_UPD;
          end
        end
        S_UPD: begin
          sum    <= sum_next;
          count  <= count_next;
          rd_ptr <= rd_ptr_next;
          wr_ptr <= wr_ptr_next;
          state  <= (count_next != '0) ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r    <= cmd_t'(command);
      sample_r <= sample;
    end
    if (state == S_UPD) begin
      status_r <= (!is_put && !held) ? STATUS_EMPTY : STATUS_OK;
      popped_r <= (!is_put && held) ? rdata : '0;
      avg_r    <= '0;
    end else if (state == S_DIV && div_done) begin
      avg_r <= div_quo;
    end
    if (state == S_OUT && out_free) begin
      status       <= status_r;
      popped_value <= popped_r;
      fill_count   <= FILL_W'(count);
      window_sum   <= OUT_SUM_W'(sum);
      average      <= avg_r;
    end
  end

endmodule

/* sv/mavg_ram.sv */
// Sample store: one write port, one read port, registered read data.
// Depends on mavg_pkg for depth and sample width.
module mavg_ram
  import mavg_pkg::*;
(
  input  logic                          clk,
  input  logic                          we,
  input  logic [PTR_W-1:0]              waddr,
  input  logic signed [SAMPLE_BITS-1:0] wdata,
  input  logic [PTR_W-1:0]              raddr,
  output logic signed [SAMPLE_BITS-1:0] rdata
);

  logic signed [SAMPLE_BITS-1:0] mem [MAX_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/mavg_div.sv */
// Serial signed divider: sum / count, truncated toward zero, one bit a cycle.
// Depends on mavg_pkg for widths. Divisor must be nonzero.
module mavg_div
  import mavg_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SUM_W-1:0]       dividend,
  input  logic [LEN_W-1:0]              divisor,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic              neg;
  logic [LEN_W-1:0]  dvs;
  logic [LEN_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;

  logic [LEN_W:0]    rem_sh;
  logic              take;
  logic [LEN_W:0]    rem_sub;

  always_comb begin
    rem_sh  = {rem, quo[SUM_W-1]};
    take    = (rem_sh >= {1'b0, dvs});
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (steps == STEP_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      steps <= STEP_W'(SUM_W);
      neg   <= dividend[SUM_W-1];
      dvs   <= divisor;
      rem   <= '0;
      quo   <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      rem   <= take ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      quo   <= {quo[SUM_W-2:0], take};
    end
  end

  // magnitude quotient fits the sample width, so truncation after negation is exact
  assign quotient = neg ? SAMPLE_BITS'(-quo) : SAMPLE_BITS'(quo);

endmodule

/* tb/tb.sv */
// Self-checking testbench for the moving-average ring buffer.
// Depends on mavg_pkg and moving_average_ring_buffer; a built-in predictor sets the expected results.
module tb;
  import mavg_pkg::*;

  typedef struct packed {
    logic                          status;
    logic signed [SAMPLE_BITS-1:0] popped;
    logic [FILL_W-1:0]             fill;
    logic signed [OUT_SUM_W-1:0]   sum;
    logic signed [SAMPLE_BITS-1:0] avg;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_W-1:0]              window_length = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          command = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          status;
  logic signed [SAMPLE_BITS-1:0] popped_value;
  logic [FILL_W-1:0]             fill_count;
  logic signed [OUT_SUM_W-1:0]   window_sum;
  logic signed [SAMPLE_BITS-1:0] average;

  moving_average_ring_buffer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_length(window_length),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .popped_value (popped_value),
    .fill_count   (fill_count),
    .window_sum   (window_sum),
    .average      (average)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted ring state, mirrors the block after each accepted transfer.
  logic signed [SAMPLE_BITS-1:0] ring_copy [MAX_DEPTH];
  logic [CFG_W-1:0]              ring_len_reg = 7'd64;
  int                            ring_wr   = 0;
  int                            ring_rd   = 0;
  int                            ring_held = 0;
  int                            ring_sum  = 0;

  result_t pending_results [$];
  int      mismatches = 0;
  bit      steady = 1'b0;   // when set, neither side inserts gaps

  // Gap length: mostly none or short, now and then long.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Samples lean on the extremes and on small values so sums and averages
  // cross zero often; the rest is uniform over the full range.
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    if (r == 2) return $signed(16'($urandom_range(0, 30))) - 16'sd15;
    return 16'($urandom);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] drop_oldest(input int len);
    logic signed [SAMPLE_BITS-1:0] v;
    v         = ring_copy[ring_rd];
    ring_sum  = ring_sum - v;
    ring_rd   = (ring_rd + 1 >= len) ? 0 : ring_rd + 1;
    ring_held = ring_held - 1;
    return v;
  endfunction

  // Applies one command to the predicted ring and returns the result it yields.
  function automatic result_t advance_window(input cmd_t cmd,
                                             input logic signed [SAMPLE_BITS-1:0] smp);
    result_t r;
    int      len;
    len = (ring_len_reg == 0) ? 1 :
          (ring_len_reg > MAX_DEPTH) ? MAX_DEPTH : int'(ring_len_reg);
    r.status = STATUS_OK;
    r.popped = '0;
    if (cmd == CMD_PUT) begin
      // full window: oldest sample leaves first
      if (ring_held >= len) void'(drop_oldest(len));
      ring_copy[ring_wr] = smp;
      ring_wr   = (ring_wr + 1 >= len) ? 0 : ring_wr + 1;
      ring_held = ring_held + 1;
      ring_sum  = ring_sum + smp;
    end else if (ring_held == 0) begin
      r.status = STATUS_EMPTY;   // state left as is
    end else begin
      r.popped = drop_oldest(len);
    end
    r.fill = FILL_W'(ring_held);
    r.sum  = OUT_SUM_W'(ring_sum);
    r.avg  = (ring_held != 0) ? SAMPLE_BITS'(ring_sum / ring_held) : '0;
    return r;
  endfunction

  // One transfer on the input channel; the expectation is queued when accepted.
  task automatic send_item(input cmd_t cmd, input logic signed [SAMPLE_BITS-1:0] smp);
    int gap;
    gap = steady ? 0 : gap_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    sample   <= smp;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(advance_window(cmd, smp));
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Window length change, only with the block idle; restarts the ring.
  task automatic write_window(input logic [CFG_W-1:0] len);
    drain_results();
    cfg_valid     <= 1'b1;
    window_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    ring_len_reg  = len;
    ring_wr       = 0;
    ring_rd       = 0;
    ring_held     = 0;
    ring_sum      = 0;
  endtask

  // Default window after reset: empty get, sample extremes, rounding toward zero.
  task automatic test_reset_window();
    send_item(CMD_GET, 16'sh1234);
    send_item(CMD_PUT, 16'sh7fff);
    send_item(CMD_PUT, 16'sh8000);
    send_item(CMD_GET, 16'sh0000);
    send_item(CMD_GET, 16'shffff);
    send_item(CMD_GET, 16'sh0000);
    send_item(CMD_PUT, -16'sd1);
    send_item(CMD_PUT, 16'sd1);
    send_item(CMD_PUT, -16'sd3);    // sum -3 over 3: average -1
    send_item(CMD_PUT, 16'sd2);     // sum -1 over 4: average 0
    send_item(CMD_PUT, 16'sd7);
    repeat (6) send_item(CMD_GET, 16'sh0000);
  endtask

  // Short window: puts past the length drop the oldest sample.
  task automatic test_short_window();
    write_window(7'd3);
    send_item(CMD_PUT, 16'sd10);
    send_item(CMD_PUT, 16'sd20);
    send_item(CMD_PUT, 16'sd30);
    send_item(CMD_PUT, 16'sd40);
    send_item(CMD_PUT, -16'sd50);
    repeat (4) send_item(CMD_GET, 16'sh7fff);
  endtask

  // Register value 0 acts as a one-sample window.
  task automatic test_zero_length();
    write_window(7'd0);
    send_item(CMD_PUT, 16'sd100);
    send_item(CMD_PUT, -16'sd200);
    send_item(CMD_GET, 16'sh0000);
    send_item(CMD_GET, 16'sh0000);
  endtask

  // Full 64-sample window at both extremes: largest and smallest sums.
  task automatic test_full_window_sums();
    write_window(7'd64);
    steady = 1'b1;
    repeat (66) send_item(CMD_PUT, 16'sh7fff);
    steady = 1'b0;
    repeat (66) send_item(CMD_PUT, 16'sh8000);
    repeat (65) send_item(CMD_GET, random_sample());
  endtask

  // Random command streams over a range of window lengths, the out-of-range
  // register values among them; put rate varies so the ring both fills and empties.
  task automatic test_random_windows();
    logic [CFG_W-1:0] lengths [9];
    int               put_pct;
    lengths = '{7'd1, 7'd2, 7'd5, 7'd16, 7'd63, 7'd64, 7'd65, 7'd127, 7'd0};
    lengths[8] = CFG_W'($urandom_range(0, 127));
    for (int p = 0; p < 9; p++) begin
      write_window(lengths[p]);
      steady = (p % 3 == 1);
      for (int i = 0; i < 120; i++) begin
        put_pct = (i < 60) ? 75 : (p % 2 == 0) ? 50 : 30;
        send_item(($urandom_range(0, 99) < put_pct) ? CMD_PUT : CMD_GET,
                  random_sample());
        // hold off mid-phase until everything is back
        if (i == 70) drain_results();
      end
      steady = 1'b0;
    end
  endtask

  // Receiver stalls at random, with steady stretches in between.
  initial begin
    int n;
    forever begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      n = steady ? 0 : gap_cycles();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result check: each transfer against the oldest expectation.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, popped_value, fill_count, window_sum, average};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d popped %0d fill %0d sum %0d avg %0d",
                   got.status, $signed(got.popped), got.fill, $signed(got.sum),
                   $signed(got.avg));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d pop %0d fill %0d sum %0d avg %0d | got st %0d pop %0d fill %0d sum %0d avg %0d",
                     want.status, $signed(want.popped), want.fill, $signed(want.sum),
                     $signed(want.avg), got.status, $signed(got.popped), got.fill,
                     $signed(got.sum), $signed(got.avg));
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_window();
    test_short_window();
    test_zero_length();
    test_full_window_sums();
    test_random_windows();
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #1500000;
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
sv/mavg_pkg.sv
sv/mavg_ram.sv
sv/mavg_div.sv
sv/moving_average_ring_buffer.sv
tb/tb.sv
